>>> rtl/serial_frame_command_receiver_macros.svh
// assertion macros used by the frame deframer module
`ifndef SERIAL_FRAME_COMMAND_RECEIVER_MACROS_SVH
`define SERIAL_FRAME_COMMAND_RECEIVER_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define SFCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define SFCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sfcr_pkg.sv
// types, constants and command decoder for the serial frame receiver
`timescale 1ns / 1ps
package sfcr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hA0;
  localparam logic [7:0] SYNC_SECOND = 8'hA1;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  localparam int unsigned HEAD_DEPTH = 3;
  localparam int unsigned HEAD_IDX_W = $clog2(HEAD_DEPTH);

  // command groups and sub-codes
  localparam logic [7:0] GRP_CTRL     = 8'd10;
  localparam logic [7:0] GRP_IGN_A    = 8'd20;
  localparam logic [7:0] GRP_IGN_B    = 8'd21;
  localparam logic [7:0] GRP_IGN_C    = 8'd30;
  localparam logic [7:0] GRP_IGN_D    = 8'd31;
  localparam logic [7:0] GRP_IGN_E    = 8'd40;
  localparam logic [7:0] GRP_IGN_F    = 8'd41;
  localparam logic [7:0] SUB_TEST     = 8'd5;
  localparam logic [7:0] SUB_SET_RATE = 8'd6;
  localparam logic [7:0] SUB_ACK      = 8'd7;
  localparam logic [7:0] SUB_NACK     = 8'd8;
  localparam logic [7:0] SUB_LISTEN   = 8'd9;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_TEST       = 3'd1,
    ACT_SET_RATE   = 3'd2,
    ACT_ACK_SEEN   = 3'd3,
    ACT_NACK_SEEN  = 3'd4,
    ACT_LISTEN     = 3'd5,
    ACT_REPLY_NACK = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CSUM    = 3'd4,
    PH_CR      = 3'd5,
    PH_LF      = 3'd6
  } phase_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] group_code;
    logic [7:0] sub_code;
    logic [7:0] argument;
  } cmd_t;

  // byte transfer from the input register into the deframer
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_xfer_t;

  function automatic action_t decode_action(input logic [7:0] grp, input logic [7:0] sub);
    action_t act;
    act = ACT_REPLY_NACK;
    unique case (grp) inside
      GRP_CTRL: begin
        unique case (sub) inside
          SUB_TEST:     act = ACT_TEST;
          SUB_SET_RATE: act = ACT_SET_RATE;
          SUB_ACK:      act = ACT_ACK_SEEN;
          SUB_NACK:     act = ACT_NACK_SEEN;
          SUB_LISTEN:   act = ACT_LISTEN;
          default:      act = ACT_REPLY_NACK;
        endcase
      end
      GRP_IGN_A, GRP_IGN_B, GRP_IGN_C, GRP_IGN_D, GRP_IGN_E, GRP_IGN_F: act = ACT_NONE;
      default: act = ACT_REPLY_NACK;
    endcase
    return act;
  endfunction

endpackage

>>> rtl/sfcr_in_reg.sv
// input register stage for received bytes
`timescale 1ns / 1ps
module sfcr_in_reg
  import sfcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output byte_xfer_t held_o,
  input  logic       take_i
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;

  assign in_ready = !vld_r || take_i;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take_i) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_rx_byte;
    end
  end

  assign held_o.vld  = vld_r;
  assign held_o.data = data_r;

endmodule

>>> rtl/sfcr_deframer.sv
// phase machine, payload head store and command decode
`timescale 1ns / 1ps
`include "serial_frame_command_receiver_macros.svh"
module sfcr_deframer
  import sfcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       done_o,
  output cmd_t       cmd_o
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] head_r   [HEAD_DEPTH];
  logic [7:0] head_nxt [HEAD_DEPTH];
  logic [8:0] cnt_inc;

  assign cnt_inc = {1'b0, cnt_r} + 9'd1;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    done_o    = 1'b0;
    if (step_i) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (byte_i == SYNC_FIRST) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          phase_nxt = (byte_i == SYNC_SECOND) ? PH_LEN : PH_HUNT;
        end
        PH_LEN: begin
          len_nxt = byte_i;
          cnt_nxt = '0;
          for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_nxt[i] = '0;
          end
          phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          // only the head of the payload is kept, later bytes are just counted
          if (cnt_r < 8'(HEAD_DEPTH)) head_nxt[cnt_r[HEAD_IDX_W-1:0]] = byte_i;
          // zero length still ends after one byte
          if (cnt_inc >= {1'b0, len_r}) phase_nxt = PH_CSUM;
          cnt_nxt = cnt_inc[8] ? 8'hFF : cnt_inc[7:0];
        end
        PH_CSUM: begin
          phase_nxt = PH_CR;
        end
        PH_CR: begin
          phase_nxt = (byte_i == CHAR_CR) ? PH_LF : PH_HUNT;
        end
        PH_LF: begin
          done_o    = (byte_i == CHAR_LF);
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  assign cmd_o.action     = decode_action(head_r[0], head_r[1]);
  assign cmd_o.group_code = head_r[0];
  assign cmd_o.sub_code   = head_r[1];
  assign cmd_o.argument   = head_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      cnt_r   <= '0;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
    end
  end

  `SFCR_ASSERT_NOW(a_done_only_in_lf, done_o, step_i && phase_r == PH_LF, "result outside lf phase")
  `SFCR_ASSERT_NEXT(a_hold_when_idle, !step_i, phase_r == $past(phase_r) && $stable(cnt_r), "deframer moved without a byte")
  `SFCR_ASSERT_NEXT(a_len_clears_head, step_i && phase_r == PH_LEN, phase_r == PH_PAYLOAD && cnt_r == 8'd0 && head_r[2] == 8'd0, "length byte did not restart payload")
  `SFCR_ASSERT_NEXT(a_lf_returns_hunt, step_i && phase_r == PH_LF, phase_r == PH_HUNT, "no return to hunting after lf")

endmodule

>>> rtl/sfcr_out_reg.sv
// result register holding one decoded command
`timescale 1ns / 1ps
module sfcr_out_reg
  import sfcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  cmd_t       cmd_i,
  output logic       full_o,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_action,
  output logic [7:0] out_group_code,
  output logic [7:0] out_sub_code,
  output logic [7:0] out_argument
);

  logic vld_r, vld_nxt;
  cmd_t cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load_i) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      cmd_r <= cmd_i;
    end
  end

  assign full_o         = vld_r;
  assign out_valid      = vld_r;
  assign out_action     = cmd_r.action;
  assign out_group_code = cmd_r.group_code;
  assign out_sub_code   = cmd_r.sub_code;
  assign out_argument   = cmd_r.argument;

endmodule

>>> rtl/serial_frame_command_receiver.sv
// path: a byte transfer is held in the input register before the deframer takes it; a
// frame-ending lf loads its command into the result register, which raises out_valid
// throughput: one byte per cycle unless a waiting command is not being taken;
// while a command waits to be taken the deframer halts and input stops once it holds a byte
// reset: synchronous active-low rst_n empties both registers, clears the payload
// head and returns the phase machine to sync hunting
`timescale 1ns / 1ps
module serial_frame_command_receiver
  import sfcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_action,
  output logic [7:0] out_group_code,
  output logic [7:0] out_sub_code,
  output logic [7:0] out_argument
);

  byte_xfer_t held;
  logic       take;
  logic       done;
  logic       out_full;
  cmd_t       cmd;

  // a held byte moves on unless the result register holds a command that is not being taken
  assign take = held.vld && (!out_full || out_ready);

  sfcr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .held_o     (held),
    .take_i     (take)
  );

  sfcr_deframer u_deframer (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (take),
    .byte_i (held.data),
    .done_o (done),
    .cmd_o  (cmd)
  );

  sfcr_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (done),
    .cmd_i          (cmd),
    .full_o         (out_full),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_group_code (out_group_code),
    .out_sub_code   (out_sub_code),
    .out_argument   (out_argument)
  );

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the serial frame command receiver
`timescale 1ns / 1ps
module tb_top;
  import sfcr_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES = 1300;
  localparam int unsigned FINAL_BYTES = 1700;

  typedef enum int {
    FLAW_NONE,
    FLAW_SYNC,
    FLAW_CR,
    FLAW_LF
  } frame_flaw_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_action;
  logic [7:0] out_group_code;
  logic [7:0] out_sub_code;
  logic [7:0] out_argument;

  // predictor state of the deframer
  phase_t     rx_phase = PH_HUNT;
  logic [7:0] rx_length = 8'h00;
  logic [7:0] rx_count = 8'h00;
  logic [7:0] rx_head [3] = '{8'h00, 8'h00, 8'h00};

  cmd_t        pending_cmds [$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  serial_frame_command_receiver i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_group_code (out_group_code),
    .out_sub_code   (out_sub_code),
    .out_argument   (out_argument)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic action_t command_action(input logic [7:0] grp, input logic [7:0] sub);
    action_t act;
    act = ACT_REPLY_NACK;
    if (grp == GRP_CTRL) begin
      if (sub == SUB_TEST) act = ACT_TEST;
      else if (sub == SUB_SET_RATE) act = ACT_SET_RATE;
      else if (sub == SUB_ACK) act = ACT_ACK_SEEN;
      else if (sub == SUB_NACK) act = ACT_NACK_SEEN;
      else if (sub == SUB_LISTEN) act = ACT_LISTEN;
    end else if (grp == GRP_IGN_A || grp == GRP_IGN_B || grp == GRP_IGN_C ||
                 grp == GRP_IGN_D || grp == GRP_IGN_E || grp == GRP_IGN_F) begin
      act = ACT_NONE;
    end
    return act;
  endfunction

  // advance the deframer by one byte, returns a command on a good frame end
  task automatic deframe_byte(input logic [7:0] value, output bit has_cmd, output cmd_t cmd);
    logic [8:0] next_count;
    has_cmd = 1'b0;
    cmd = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (value == SYNC_FIRST) rx_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        rx_phase = (value == SYNC_SECOND) ? PH_LEN : PH_HUNT;
      end
      PH_LEN: begin
        rx_length = value;
        rx_count = 8'h00;
        rx_head = '{8'h00, 8'h00, 8'h00};
        rx_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        next_count = {1'b0, rx_count} + 9'd1;
        if (rx_count < 8'(HEAD_DEPTH)) rx_head[rx_count[HEAD_IDX_W-1:0]] = value;
        // a zero length still takes one byte since next_count is at least one
        if (next_count >= {1'b0, rx_length}) rx_phase = PH_CSUM;
        rx_count = next_count[8] ? 8'hFF : next_count[7:0];
      end
      PH_CSUM: rx_phase = PH_CR;
      PH_CR: begin
        rx_phase = (value == CHAR_CR) ? PH_LF : PH_HUNT;
      end
      PH_LF: begin
        if (value == CHAR_LF) begin
          has_cmd = 1'b1;
          cmd.action = command_action(rx_head[0], rx_head[1]);
          cmd.group_code = rx_head[0];
          cmd.sub_code = rx_head[1];
          cmd.argument = rx_head[2];
        end
        rx_phase = PH_HUNT;
      end
      default: rx_phase = PH_HUNT;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s: got 0x%02h, expected 0x%02h",
             $realtime, what, got, want);
  endtask

  // one byte transfer on the input channel, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] value);
    bit   has_cmd;
    cmd_t cmd;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    do @(posedge clk); while (!in_ready);
    deframe_byte(value, has_cmd, cmd);
    if (has_cmd) pending_cmds.push_back(cmd);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] grp, input logic [7:0] sub,
                            input logic [7:0] arg, input frame_flaw_t flaw);
    int unsigned n_payload;
    logic [7:0]  bad;
    n_payload = (len == 8'h00) ? 1 : 32'(len);
    send_byte(SYNC_FIRST);
    if (flaw == FLAW_SYNC) begin
      do bad = 8'($urandom_range(0, 255)); while (bad == SYNC_SECOND);
      send_byte(bad);
    end else begin
      send_byte(SYNC_SECOND);
    end
    send_byte(len);
    for (int unsigned i = 0; i < n_payload; i++) begin
      if (i == 0) send_byte(grp);
      else if (i == 1) send_byte(sub);
      else if (i == 2) send_byte(arg);
      else send_byte(8'($urandom_range(0, 255)));
    end
    send_byte(8'($urandom_range(0, 255)));
    if (flaw == FLAW_CR) begin
      do bad = 8'($urandom_range(0, 255)); while (bad == CHAR_CR);
      send_byte(bad);
    end else begin
      send_byte(CHAR_CR);
    end
    if (flaw == FLAW_LF) begin
      do bad = 8'($urandom_range(0, 255)); while (bad == CHAR_LF);
      send_byte(bad);
    end else begin
      send_byte(CHAR_LF);
    end
  endtask

  task automatic send_random_frame(input frame_flaw_t flaw);
    logic [7:0] len;
    logic [7:0] grp;
    logic [7:0] sub;
    logic [7:0] ign_groups [6];
    ign_groups = '{GRP_IGN_A, GRP_IGN_B, GRP_IGN_C, GRP_IGN_D, GRP_IGN_E, GRP_IGN_F};
    len = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(6, 20));
    case ($urandom_range(0, 3))
      0, 1: grp = GRP_CTRL;
      2: grp = ign_groups[3'($urandom_range(0, 5))];
      default: grp = 8'($urandom_range(0, 255));
    endcase
    if (grp == GRP_CTRL && $urandom_range(0, 3) != 0) sub = 8'($urandom_range(5, 9));
    else sub = 8'($urandom_range(0, 255));
    send_frame(len, grp, sub, 8'($urandom_range(0, 255)), flaw);
  endtask

  task automatic test_framing_errors();
    // bad second sync byte: the repeated sync-first byte is not taken as a new start
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    // zero length still carries one payload byte
    send_frame(8'h00, 8'hFF, 8'h00, 8'h00, FLAW_NONE);
    send_frame(8'h01, GRP_CTRL, 8'h00, 8'h00, FLAW_CR);
    send_frame(8'h01, GRP_IGN_A, 8'h00, 8'h00, FLAW_LF);
  endtask

  task automatic test_long_payload();
    send_frame(8'hFF, GRP_CTRL, SUB_LISTEN, 8'hFF, FLAW_NONE);
    send_frame(8'h04, 8'h00, 8'hFF, 8'h00, FLAW_NONE);
  endtask

  task automatic test_random_frames(input int unsigned byte_goal);
    frame_flaw_t flaw;
    while (bytes_sent < byte_goal) begin
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 9))
        0: flaw = FLAW_SYNC;
        1: flaw = FLAW_CR;
        2: flaw = FLAW_LF;
        default: flaw = FLAW_NONE;
      endcase
      send_random_frame(flaw);
    end
  endtask

  // receiver holds off while frames keep arriving, so the block backs up
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    hold_requests++;
    repeat (8) send_random_frame(FLAW_NONE);
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        // a command transfer with nothing expected
        report_mismatch("out_valid", 8'h01, 8'h00);
      end else begin
        want = pending_cmds.pop_front();
        if (out_action != want.action)
          report_mismatch("action", {5'b0, out_action}, {5'b0, want.action});
        if (out_group_code != want.group_code)
          report_mismatch("group_code", out_group_code, want.group_code);
        if (out_sub_code != want.sub_code)
          report_mismatch("sub_code", out_sub_code, want.sub_code);
        if (out_argument != want.argument)
          report_mismatch("argument", out_argument, want.argument);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_framing_errors();
    test_long_payload();
    test_random_frames(RANDOM_BYTES);
    test_output_backpressure();
    // no idling on either side from here on
    idle_on = 1'b0;
    test_random_frames(FINAL_BYTES);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("%0t ns: timeout", $realtime);
    $display("Regression FAIL");
    $finish;
  end

endmodule
